[rtl/dqs_pkg.sv]
package dqs_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_CONTAINS  = 3'd4,
        OP_REM_VALUE = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RD_FRONT,
        ST_RD_BACK,
        ST_RD_DONE,
        ST_OUT
    } state_t;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[rtl/dqs_if.sv]
interface dqs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dqs_pkg::OP_W-1:0]      operation;
    logic signed [dqs_pkg::VALUE_BITS-1:0] item_value;

    modport source (output valid, output operation, output item_value, input ready);
    modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface dqs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dqs_pkg::STATUS_W-1:0]  status;
    logic                          found;
    logic signed [dqs_pkg::VALUE_BITS-1:0] front_value;
    logic signed [dqs_pkg::VALUE_BITS-1:0] back_value;
    logic [dqs_pkg::CNT_W-1:0]     entry_count;
    logic                          is_empty;

    modport source (output valid, output status, output found, output front_value,
                    output back_value, output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input found, input front_value,
                    input back_value, input entry_count, input is_empty, output ready);
endinterface

[rtl/double_ended_queue_with_search.sv]
// Bounded double-ended queue with search and remove-by-value.
// cmd carries one item per operation (operation, item_value); rsp returns one
// result per item: status, found, front/back after the operation, count, empty.
// Both channels move an item when valid and ready are high at a rising edge.
// Entries live in one synchronous RAM of DEPTH words with a registered read.
// One item is worked at a time; cmd.ready is high only while the block idles.
// Adds and removes at either end read the new front and back entries from the
// RAM (RD_FRONT, RD_BACK, RD_DONE), then load the output register in OUT;
// rsp.valid rises with that load and the block returns to idle for the next item.
// Contains and remove value first scan entries from the front (SCAN_RD, SCAN_CMP),
// and remove value then closes the gap (SHIFT_RD read, then SHIFT_WR write back).
// An add when full or a remove when empty leaves the queue alone and flags
// status. A stalled rsp holds its result in the output register; the block
// then waits before the final load and takes no new item until it drains.
// Reset clears head, count and control; RAM contents stay undefined.
module double_ended_queue_with_search (
    input  logic       clk,
    input  logic       rst_n,
    dqs_cmd_if.sink    cmd,
    dqs_rsp_if.source  rsp
);

    dqs_pkg::state_t                   state_reg, state_next;
    logic [dqs_pkg::IDX_W-1:0]         head_reg, head_next;
    logic [dqs_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [dqs_pkg::IDX_W-1:0]         pos_reg, pos_next;
    dqs_pkg::op_t                      op_reg, op_next;
    logic [dqs_pkg::VALUE_BITS-1:0]    value_reg, value_next;
    dqs_pkg::status_t                  status_reg, status_next;
    logic                              found_reg, found_next;
    logic [dqs_pkg::VALUE_BITS-1:0]    front_reg, front_next;
    logic [dqs_pkg::VALUE_BITS-1:0]    back_reg, back_next;

    logic                              out_valid_reg, out_valid_next;
    dqs_pkg::status_t                  out_status_reg, out_status_next;
    logic                              out_found_reg, out_found_next;
    logic [dqs_pkg::VALUE_BITS-1:0]    out_front_reg, out_front_next;
    logic [dqs_pkg::VALUE_BITS-1:0]    out_back_reg, out_back_next;
    logic [dqs_pkg::CNT_W-1:0]         out_count_reg, out_count_next;

    logic [dqs_pkg::VALUE_BITS-1:0]    entry_store [dqs_pkg::DEPTH];
    logic [dqs_pkg::VALUE_BITS-1:0]    rdata_reg;
    logic [dqs_pkg::IDX_W-1:0]         raddr;
    logic                              we;
    logic [dqs_pkg::IDX_W-1:0]         waddr;
    logic [dqs_pkg::VALUE_BITS-1:0]    wdata;

    logic                              accept;
    logic                              is_full;
    logic                              is_zero;
    logic                              match;
    logic                              scan_last;
    logic                              shift_last;
    logic                              out_free;
    logic [dqs_pkg::IDX_W-1:0]         head_dec;
    logic [dqs_pkg::IDX_W-1:0]         head_inc;
    logic [dqs_pkg::IDX_W-1:0]         last_pos;

    assign accept     = (state_reg == dqs_pkg::ST_IDLE) && cmd.valid;
    assign is_full    = (count_reg == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
    assign is_zero    = (count_reg == '0);
    assign match      = (rdata_reg == value_reg);
    assign scan_last  = ((dqs_pkg::CNT_W'(pos_reg) + dqs_pkg::CNT_W'(1)) == count_reg);
    assign shift_last = !((dqs_pkg::CNT_W'(pos_reg) + dqs_pkg::CNT_W'(2)) < count_reg);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign head_dec   = (head_reg == '0) ? dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1)
                                         : head_reg - dqs_pkg::IDX_W'(1);
    assign head_inc   = (head_reg == dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1)) ? '0
                                         : head_reg + dqs_pkg::IDX_W'(1);
    assign last_pos   = is_zero ? '0 : dqs_pkg::IDX_W'(count_reg - dqs_pkg::CNT_W'(1));

    assign cmd.ready       = (state_reg == dqs_pkg::ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.back_value  = out_back_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.is_empty    = (out_count_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dqs_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if ((cmd.operation == dqs_pkg::OP_CONTAINS ||
                         cmd.operation == dqs_pkg::OP_REM_VALUE) && !is_zero)
                    begin
                        state_next = dqs_pkg::ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = dqs_pkg::ST_RD_FRONT;
                    end
                end
            end
            dqs_pkg::ST_SCAN_RD:
            begin
                state_next = dqs_pkg::ST_SCAN_CMP;
            end
            dqs_pkg::ST_SCAN_CMP:
            begin
                priority if (match)
                begin
                    if (op_reg == dqs_pkg::OP_REM_VALUE && !scan_last)
                    begin
                        state_next = dqs_pkg::ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = dqs_pkg::ST_RD_FRONT;
                    end
                end
                else if (scan_last)
                begin
                    state_next = dqs_pkg::ST_RD_FRONT;
                end
                else
                begin
                    state_next = dqs_pkg::ST_SCAN_RD;
                end
            end
            dqs_pkg::ST_SHIFT_RD:
            begin
                state_next = dqs_pkg::ST_SHIFT_WR;
            end
            dqs_pkg::ST_SHIFT_WR:
            begin
                state_next = shift_last ? dqs_pkg::ST_RD_FRONT : dqs_pkg::ST_SHIFT_RD;
            end
            dqs_pkg::ST_RD_FRONT:
            begin
                state_next = dqs_pkg::ST_RD_BACK;
            end
            dqs_pkg::ST_RD_BACK:
            begin
                state_next = dqs_pkg::ST_RD_DONE;
            end
            dqs_pkg::ST_RD_DONE:
            begin
                state_next = dqs_pkg::ST_OUT;
            end
            dqs_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = dqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_count_next  = out_count_reg;
        raddr           = '0;
        we              = 1'b0;
        waddr           = '0;
        wdata           = cmd.item_value;

        unique case (state_reg)
            dqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = dqs_pkg::op_t'(cmd.operation);
                    value_next  = cmd.item_value;
                    status_next = dqs_pkg::STATUS_DONE;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    unique case (cmd.operation)
                        dqs_pkg::OP_ADD_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = dqs_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                head_next  = head_dec;
                                count_next = count_reg + dqs_pkg::CNT_W'(1);
                                we         = 1'b1;
                                waddr      = head_dec;
                            end
                        end
                        dqs_pkg::OP_ADD_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = dqs_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + dqs_pkg::CNT_W'(1);
                                we         = 1'b1;
                                waddr      = dqs_pkg::slot_of(head_reg,
                                                 dqs_pkg::IDX_W'(count_reg));
                            end
                        end
                        dqs_pkg::OP_REM_FRONT:
                        begin
                            if (is_zero)
                            begin
                                status_next = dqs_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - dqs_pkg::CNT_W'(1);
                            end
                        end
                        dqs_pkg::OP_REM_BACK:
                        begin
                            if (is_zero)
                            begin
                                status_next = dqs_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - dqs_pkg::CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dqs_pkg::ST_SCAN_RD:
            begin
                raddr = dqs_pkg::slot_of(head_reg, pos_reg);
            end
            dqs_pkg::ST_SCAN_CMP:
            begin
                priority if (match)
                begin
                    found_next = 1'b1;
                    if (op_reg == dqs_pkg::OP_REM_VALUE && scan_last)
                    begin
                        count_next = count_reg - dqs_pkg::CNT_W'(1);
                    end
                end
                else if (!scan_last)
                begin
                    pos_next = pos_reg + dqs_pkg::IDX_W'(1);
                end
            end
            dqs_pkg::ST_SHIFT_RD:
            begin
                raddr = dqs_pkg::slot_of(head_reg, pos_reg + dqs_pkg::IDX_W'(1));
            end
            dqs_pkg::ST_SHIFT_WR:
            begin
                we       = 1'b1;
                waddr    = dqs_pkg::slot_of(head_reg, pos_reg);
                wdata    = rdata_reg;
                pos_next = pos_reg + dqs_pkg::IDX_W'(1);
                if (shift_last)
                begin
                    count_next = count_reg - dqs_pkg::CNT_W'(1);
                end
            end
            dqs_pkg::ST_RD_FRONT:
            begin
                raddr = head_reg;
            end
            dqs_pkg::ST_RD_BACK:
            begin
                raddr      = dqs_pkg::slot_of(head_reg, last_pos);
                front_next = rdata_reg;
            end
            dqs_pkg::ST_RD_DONE:
            begin
                back_next = rdata_reg;
            end
            dqs_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                    out_front_next  = is_zero ? '0 : front_reg;
                    out_back_next   = is_zero ? '0 : back_reg;
                    out_count_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_store[waddr] <= wdata;
        end
        rdata_reg <= entry_store[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqs_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        op_reg         <= op_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_count_reg  <= out_count_next;
    end

endmodule
